FILE: design/rgb_kernel_convolution_assert.svh
// ----------------------------------------------------------------------------
// rgb_kernel_convolution_assert.svh
// Assertion macros shared by the convolution RTL.
// ----------------------------------------------------------------------------
`ifndef RGB_KERNEL_CONVOLUTION_ASSERT_SVH
`define RGB_KERNEL_CONVOLUTION_ASSERT_SVH

// Condition now implies a consequence in the same cycle.
`define RKC_ASSERT_NOW(lbl, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (con)) else $error(msg);

// Condition now implies a consequence in the next cycle.
`define RKC_ASSERT_NEXT(lbl, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (con)) else $error(msg);

`endif

FILE: design/rkc_pkg.sv
// ----------------------------------------------------------------------------
// rkc_pkg
// Types, constants and helpers of the RGB kernel convolution block.
// ----------------------------------------------------------------------------
`default_nettype none

package rkc_pkg;

	localparam int PIX_W      = 8;
	localparam int CH_N       = 3;
	localparam int SAMPLE_W   = PIX_W * CH_N;
	localparam int COEF_W     = 12;
	localparam int KDIM       = 5;
	localparam int KROW_W     = COEF_W * KDIM;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = KROW_W;
	localparam int DIM_W      = 11;
	localparam int ROW_W      = 11;
	localparam int RAD_W      = 2;
	localparam int H_MAX      = 1024;
	localparam int PROD_W     = COEF_W + PIX_W + 1;
	localparam int ACC_W      = PROD_W + 7;

	localparam logic [KROW_W-1:0] KROW_IDENT = 60'h0_0001_0000_0000;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic signed [COEF_W-1:0] coef_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KERNEL_RADIUS = 3'd0,
		REG_IMAGE_WIDTH   = 3'd1,
		REG_IMAGE_HEIGHT  = 3'd2,
		REG_KERNEL_ROW_0  = 3'd3,
		REG_KERNEL_ROW_1  = 3'd4,
		REG_KERNEL_ROW_2  = 3'd5,
		REG_KERNEL_ROW_3  = 3'd6,
		REG_KERNEL_ROW_4  = 3'd7
	} cfg_reg_t;

	// Pick coefficient c out of a packed kernel row.
	function automatic coef_t coef_at(input logic [KROW_W-1:0] row, input int c);
		return coef_t'(row[COEF_W*c +: COEF_W]);
	endfunction

endpackage

`default_nettype wire

FILE: design/rgb_kernel_convolution.sv
// ----------------------------------------------------------------------------
// rgb_kernel_convolution
// 3x3 / 5x5 zero-padded RGB convolution over a raster pixel stream.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; the whole pipeline stalls only on out_ready.
// Path: the item that completes a window passes the stage 1 to 4 registers and
//   the output register; it trails the pixel at its position by R*W+R items.
// The line store (one column history word per image column, read-modify-write)
//   sets the pace: one read and one write of it per item.
// Reset: counters, geometry, valids and registers go to their defaults at once;
//   the line store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_kernel_convolution #(
	parameter int MAX_WIDTH      = 1024,
	parameter int MAX_RADIUS     = 2,
	parameter int COEF_FRAC_BITS = 8
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_write,
	input  wire logic [rkc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [rkc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            op,
	input  wire logic [rkc_pkg::PIX_W-1:0]       red_in,
	input  wire logic [rkc_pkg::PIX_W-1:0]       green_in,
	input  wire logic [rkc_pkg::PIX_W-1:0]       blue_in,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [rkc_pkg::PIX_W-1:0]            red_out,
	output logic [rkc_pkg::PIX_W-1:0]            green_out,
	output logic [rkc_pkg::PIX_W-1:0]            blue_out,
	output logic                                 frame_end,
	output logic                                 clipped
);

`include "rgb_kernel_convolution_assert.svh"

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int WIN  = 2 * MAX_RADIUS + 1;
	localparam int HR   = 2 * MAX_RADIUS;
	localparam int DLW  = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
	localparam int SW   = rkc_pkg::SAMPLE_W;
	localparam int PW   = rkc_pkg::PIX_W;
	localparam int RW   = rkc_pkg::ROW_W;
	localparam int HW   = rkc_pkg::DIM_W;
	localparam int RADW = rkc_pkg::RAD_W;
	localparam int PRW  = rkc_pkg::PROD_W;
	localparam int AW   = rkc_pkg::ACC_W;
	localparam int NCH  = rkc_pkg::CH_N;
	localparam int KD   = rkc_pkg::KDIM;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [RADW-1:0]               radius_q;
	logic [rkc_pkg::DIM_W-1:0]     width_q;
	logic [rkc_pkg::DIM_W-1:0]     height_q;
	logic [rkc_pkg::KROW_W-1:0]    krow_q [KD];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADW'(1);
			width_q  <= rkc_pkg::DIM_W'(640);
			height_q <= rkc_pkg::DIM_W'(480);
			// identity kernel: 1.0 at the center tap only
			for (int k = 0; k < KD; k++) begin
				krow_q[k] <= (k == 2) ? rkc_pkg::KROW_IDENT : '0;
			end
		end else if (cfg_write) begin
			unique case (rkc_pkg::cfg_reg_t'(cfg_index))
				rkc_pkg::REG_KERNEL_RADIUS: radius_q  <= cfg_data[RADW-1:0];
				rkc_pkg::REG_IMAGE_WIDTH:   width_q   <= cfg_data[rkc_pkg::DIM_W-1:0];
				rkc_pkg::REG_IMAGE_HEIGHT:  height_q  <= cfg_data[rkc_pkg::DIM_W-1:0];
				rkc_pkg::REG_KERNEL_ROW_0:  krow_q[0] <= cfg_data;
				rkc_pkg::REG_KERNEL_ROW_1:  krow_q[1] <= cfg_data;
				rkc_pkg::REG_KERNEL_ROW_2:  krow_q[2] <= cfg_data;
				rkc_pkg::REG_KERNEL_ROW_3:  krow_q[3] <= cfg_data;
				rkc_pkg::REG_KERNEL_ROW_4:  krow_q[4] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Saturate the geometry registers into their legal ranges.
	logic [WW-1:0]   w_eff;
	logic [HW-1:0]   h_eff;
	logic [RADW-1:0] r_eff;

	always_comb begin
		w_eff = WW'(MAX_WIDTH);
		if (width_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(width_q) <= MAX_WIDTH) begin
			w_eff = WW'(width_q);
		end
		h_eff = HW'(rkc_pkg::H_MAX);
		if (height_q == '0) begin
			h_eff = HW'(1);
		end else if (32'(height_q) <= rkc_pkg::H_MAX) begin
			h_eff = height_q;
		end
		r_eff = RADW'(MAX_RADIUS);
		if (radius_q == '0) begin
			r_eff = RADW'(1);
		end else if (32'(radius_q) <= MAX_RADIUS) begin
			r_eff = radius_q;
		end
	end

	// ------------------------------------------------------------------
	// Global advance: every stage moves when the output register can take
	// a new result, so the input stalls while an unaccepted result waits.
	// ------------------------------------------------------------------
	logic out_valid_q;
	logic en;
	logic accept;

	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;
	assign accept   = in_valid && en;

	// ------------------------------------------------------------------
	// Stage 0: position counters, frame geometry latch, result scheduling
	// ------------------------------------------------------------------
	logic [CW-1:0]   col_q;
	logic [RW-1:0]   row_q;
	logic [WW-1:0]   cur_w_q;
	logic [HW-1:0]   cur_h_q;
	logic [RADW-1:0] cur_r_q;
	logic [DLW-1:0]  pre_q;
	logic [CW-1:0]   ox_q;
	logic [RW-1:0]   oy_q;

	logic            start;
	logic            slot;
	logic [WW-1:0]   w_use;
	logic [HW-1:0]   h_use;
	logic [RADW-1:0] r_use;
	logic [WW-1:0]   col_inc;
	logic            wrap;
	logic            emit;
	logic            last;
	logic [WW-1:0]   ox_inc;
	logic [DLW-1:0]  delay_m1;
	rkc_pkg::sample_t sample;

	always_comb begin
		start    = (row_q == '0) && (col_q == '0);
		slot     = !(start && op);
		w_use    = start ? w_eff : cur_w_q;
		h_use    = start ? h_eff : cur_h_q;
		r_use    = start ? r_eff : cur_r_q;
		col_inc  = WW'(col_q) + WW'(1);
		wrap     = col_inc >= w_use;
		emit     = !start && (pre_q == '0);
		last     = emit && (oy_q == RW'(cur_h_q - HW'(1)))
		               && (WW'(ox_q) == cur_w_q - WW'(1));
		ox_inc   = WW'(ox_q) + WW'(1);
		delay_m1 = DLW'(r_eff) * DLW'(w_eff) + DLW'(r_eff) - DLW'(1);
		// past the frame's last pixel and on drain items, feed zeros
		sample   = '0;
		if (!op && (RW'(row_q) < RW'(h_use))) begin
			sample = {blue_in, green_in, red_in};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			cur_w_q <= WW'(1);
			cur_h_q <= HW'(1);
			cur_r_q <= RADW'(1);
			pre_q   <= '0;
			ox_q    <= '0;
			oy_q    <= '0;
		end else if (accept && slot) begin
			if (start) begin
				cur_w_q <= w_eff;
				cur_h_q <= h_eff;
				cur_r_q <= r_eff;
				pre_q   <= delay_m1;
			end else if (pre_q != '0) begin
				pre_q <= pre_q - DLW'(1);
			end
			// frame done: return to the idle position
			if (last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (wrap) begin
				col_q <= '0;
				row_q <= row_q + RW'(1);
			end else begin
				col_q <= CW'(col_inc);
			end
			if (emit) begin
				if (last) begin
					ox_q <= '0;
					oy_q <= '0;
				end else if (ox_inc == cur_w_q) begin
					ox_q <= '0;
					oy_q <= oy_q + RW'(1);
				end else begin
					ox_q <= CW'(ox_inc);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: line store read-modify-write, window shift
	// ------------------------------------------------------------------
	logic             v_s1;
	logic             ov_s1;
	rkc_pkg::sample_t sample_s1;
	logic [CW-1:0]    addr_s1;
	logic [CW-1:0]    ox_s1;
	logic [RW-1:0]    oy_s1;
	logic             last_s1;
	logic [WW-1:0]    w_s1;
	logic [HW-1:0]    h_s1;
	logic [RADW-1:0]  r_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			ov_s1 <= 1'b0;
		end else if (en) begin
			v_s1  <= accept && slot;
			ov_s1 <= accept && slot && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sample_s1 <= sample;
			addr_s1   <= col_q;
			ox_s1     <= ox_q;
			oy_s1     <= oy_q;
			last_s1   <= last;
			w_s1      <= w_use;
			h_s1      <= h_use;
			r_s1      <= r_use;
		end
	end

	// history word: slot k holds the sample k+1 rows above, slot 0 newest
	logic [HR*SW-1:0] hist;
	logic [HR*SW-1:0] hist_wr;

	assign hist_wr = {hist[(HR-1)*SW-1:0], sample_s1};

	rkc_line_store #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW),
		.DW    (HR * SW)
	) u_line_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (en),
		.rd_addr (col_q),
		.wr_en   (en && v_s1),
		.wr_addr (addr_s1),
		.wr_data (hist_wr),
		.rd_data (hist)
	);

	// window rows run oldest (0) to newest (WIN-1); columns likewise
	rkc_pkg::sample_t colv [WIN];
	rkc_pkg::sample_t win_q [WIN][WIN];

	always_comb begin
		colv[WIN-1] = sample_s1;
		for (int k = 0; k < HR; k++) begin
			colv[WIN-2-k] = hist[k*SW +: SW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN; i++) begin
				for (int j = 0; j < WIN; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else if (en && v_s1) begin
			for (int i = 0; i < WIN; i++) begin
				for (int j = 0; j < WIN-1; j++) begin
					win_q[i][j] <= win_q[i][j+1];
				end
				win_q[i][WIN-1] <= colv[i];
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: border masking and coefficient products
	// ------------------------------------------------------------------
	logic             ov_s2;
	logic [CW-1:0]    ox_s2;
	logic [RW-1:0]    oy_s2;
	logic             last_s2;
	logic [WW-1:0]    w_s2;
	logic [HW-1:0]    h_s2;
	logic [RADW-1:0]  r_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_s2 <= 1'b0;
		end else if (en) begin
			ov_s2 <= ov_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ox_s2   <= ox_s1;
			oy_s2   <= oy_s1;
			last_s2 <= last_s1;
			w_s2    <= w_s1;
			h_s2    <= h_s1;
			r_s2    <= r_s1;
		end
	end

	logic                  row_ok [WIN];
	logic                  col_ok [WIN];
	rkc_pkg::coef_t        coef   [WIN][WIN];
	logic signed [PRW-1:0] prod   [WIN][WIN][NCH];
	logic signed [PRW-1:0] prod_s3 [WIN][WIN][NCH];

	// Offsets are relative to the output position; a tap outside the image
	// or outside the selected kernel reads as a zero sample.
	always_comb begin
		int off;
		int d;
		int p;
		off = WIN - 1 - int'(r_s2);
		for (int i = 0; i < WIN; i++) begin
			d = i - off;
			p = int'(oy_s2) + d;
			row_ok[i] = (d >= -int'(r_s2)) && (p >= 0) && (p < int'(h_s2));
			p = int'(ox_s2) + d;
			col_ok[i] = (d >= -int'(r_s2)) && (p >= 0) && (p < int'(w_s2));
		end
		for (int i = 0; i < WIN; i++) begin
			for (int j = 0; j < WIN; j++) begin
				coef[i][j] = '0;
				if (row_ok[i] && col_ok[j]) begin
					coef[i][j] = rkc_pkg::coef_at(krow_q[i - off + 2], j - off + 2);
				end
				for (int c = 0; c < NCH; c++) begin
					prod[i][j][c] = '0;
					if (row_ok[i] && col_ok[j]) begin
						prod[i][j][c] = PRW'(coef[i][j] *
						    $signed({1'b0, win_q[i][j][c*PW +: PW]}));
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= prod;
		end
	end

	logic ov_s3;
	logic last_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_s3 <= 1'b0;
		end else if (en) begin
			ov_s3 <= ov_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_s3 <= last_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: per-row sums
	// ------------------------------------------------------------------
	logic signed [AW-1:0] rsum    [WIN][NCH];
	logic signed [AW-1:0] rsum_s4 [WIN][NCH];

	always_comb begin
		for (int i = 0; i < WIN; i++) begin
			for (int c = 0; c < NCH; c++) begin
				rsum[i][c] = '0;
				for (int j = 0; j < WIN; j++) begin
					rsum[i][c] = rsum[i][c] + AW'(prod_s3[i][j][c]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsum_s4 <= rsum;
		end
	end

	logic ov_s4;
	logic last_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_s4 <= 1'b0;
		end else if (en) begin
			ov_s4 <= ov_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_s4 <= last_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: total, floor scale, clamp into the output register
	// ------------------------------------------------------------------
	logic signed [AW-1:0] acc    [NCH];
	logic signed [AW-1:0] scaled [NCH];
	logic [PW-1:0]        pix    [NCH];
	logic                 clip;

	always_comb begin
		clip = 1'b0;
		for (int c = 0; c < NCH; c++) begin
			acc[c] = '0;
			for (int i = 0; i < WIN; i++) begin
				acc[c] = acc[c] + rsum_s4[i][c];
			end
			scaled[c] = acc[c] >>> COEF_FRAC_BITS;
			if (scaled[c] < 0) begin
				pix[c] = '0;
				clip   = 1'b1;
			end else if (scaled[c] > AW'(255)) begin
				pix[c] = '1;
				clip   = 1'b1;
			end else begin
				pix[c] = scaled[c][PW-1:0];
			end
		end
	end

	logic [PW-1:0] red_q;
	logic [PW-1:0] green_q;
	logic [PW-1:0] blue_q;
	logic          frame_end_q;
	logic          clipped_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= ov_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red_q       <= pix[0];
			green_q     <= pix[1];
			blue_q      <= pix[2];
			frame_end_q <= last_s4;
			clipped_q   <= clip;
		end
	end

	assign out_valid = out_valid_q;
	assign red_out   = red_q;
	assign green_out = green_q;
	assign blue_out  = blue_q;
	assign frame_end = frame_end_q;
	assign clipped   = clipped_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`RKC_ASSERT_NEXT(a_idle_drain_ignored, accept && start && op,
		(row_q == '0) && (col_q == '0) && !v_s1, "drain while idle changed state")
	`RKC_ASSERT_NEXT(a_frame_end_rewinds, accept && slot && last,
		(row_q == '0) && (col_q == '0) && (ox_q == '0) && (oy_q == '0),
		"frame end did not rewind counters")
	`RKC_ASSERT_NOW(a_store_addr_in_row, v_s1, WW'(addr_s1) < w_s1,
		"line store address beyond row width")

endmodule

`default_nettype wire

FILE: design/rkc_line_store.sv
// ----------------------------------------------------------------------------
// rkc_line_store
// Column history memory with registered read and same-address forwarding.
// ----------------------------------------------------------------------------
`default_nettype none

module rkc_line_store #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 96
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          adv,
	input  wire logic [AW-1:0] rd_addr,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [DW-1:0] wr_data,
	output logic      [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;
	logic [DW-1:0] fwd_q;
	logic          hit_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			rdata_q <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
			fwd_q        <= wr_data;
		end
	end

	// a read issued in the same cycle as a write to its entry gets the forwarded data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (adv) begin
			hit_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = hit_q ? fwd_q : rdata_q;

endmodule

`default_nettype wire

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the RGB 3x3/5x5 convolution. It streams whole frames
// through the block and checks every output pixel against a predictor that runs
// on each accepted item.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam bit OP_PIXEL = 1'b0;
	localparam bit OP_DRAIN = 1'b1;
	localparam int HIST_N   = 2 * 2 * 1024 + 5;
	localparam int RANDOM_ITEMS = 1200;

	typedef struct packed {
		logic       op;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
		logic       clip;
	} filtered_pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [rkc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [rkc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic op = 1'b0;
	logic [7:0] red_in = '0, green_in = '0, blue_in = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] red_out, green_out, blue_out;
	logic frame_end, clipped;

	rgb_kernel_convolution u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.red_out(red_out), .green_out(green_out), .blue_out(blue_out),
		.frame_end(frame_end), .clipped(clipped)
	);

	always #6 clk = ~clk;

	// Items waiting to be driven, and output pixels waiting to be seen.
	pixel_item_t     pending_pixels[$];
	filtered_pixel_t expected_pixels[$];
	int errors = 0;

	// Register mirror, written only while the block is idle.
	logic [1:0]                 radius_reg = 2'd1;
	logic [10:0]                width_reg = 11'd640;
	logic [10:0]                height_reg = 11'd480;
	logic [rkc_pkg::KROW_W-1:0] krow[5] = '{default: '0, 2: rkc_pkg::KROW_IDENT};

	// Frame state of the predictor.
	logic [23:0] history[HIST_N];
	int frame_pos = 0;
	int geo_w = 1, geo_h = 1, geo_r = 1;

	// Set at a rising edge where an item was taken.
	logic in_ready_seen = 1'b0;

	function automatic int clamp_dim(input int v, input int hi);
		return (v < 1) ? 1 : (v > hi) ? hi : v;
	endfunction

	function automatic logic [7:0] scale_channel(input longint acc, inout logic clip);
		longint v;
		v = acc >>> 8;   // floor division by 2^8
		if (v < 0) begin
			clip = 1'b1;
			return 8'd0;
		end
		if (v > 255) begin
			clip = 1'b1;
			return 8'd255;
		end
		return v[7:0];
	endfunction

	// Advance the convolution state by one item; queue the pixel it releases.
	task automatic convolve_item(input pixel_item_t it);
		int total, p, delay, q, oy, ox, y, x;
		longint acc[3];
		logic [23:0] s;
		logic signed [11:0] k;
		filtered_pixel_t res;
		logic clip;
		if (frame_pos == 0) begin
			if (it.op == OP_DRAIN) return;   // drain while idle: ignore
			geo_w = clamp_dim(width_reg, 1024);
			geo_h = clamp_dim(height_reg, 1024);
			geo_r = clamp_dim(radius_reg, 2);
		end
		total = geo_w * geo_h;
		p = frame_pos;
		history[p % HIST_N] = (it.op == OP_PIXEL && p < total) ?
			{it.blue, it.green, it.red} : 24'd0;
		frame_pos++;
		delay = geo_r * geo_w + geo_r;
		if (p < delay) return;
		q = p - delay;
		oy = q / geo_w;
		ox = q % geo_w;
		acc = '{0, 0, 0};
		for (int dy = -geo_r; dy <= geo_r; dy++) begin
			y = oy + dy;
			if (y < 0 || y >= geo_h) continue;
			for (int dx = -geo_r; dx <= geo_r; dx++) begin
				x = ox + dx;
				if (x < 0 || x >= geo_w) continue;
				s = history[(y * geo_w + x) % HIST_N];
				k = krow[dy + 2][12 * (dx + 2) +: 12];
				for (int ch = 0; ch < 3; ch++)
					acc[ch] += longint'(k) * longint'(s[8 * ch +: 8]);
			end
		end
		clip = 1'b0;
		res.red   = scale_channel(acc[0], clip);
		res.green = scale_channel(acc[1], clip);
		res.blue  = scale_channel(acc[2], clip);
		res.last  = (q == total - 1);
		res.clip  = clip;
		if (res.last) frame_pos = 0;
		expected_pixels.insert(expected_pixels.size(), res);
	endtask

	// Sender: bursts of random length separated by random gaps.
	int burst_left = 0, gap_left = 0;
	always @(negedge clk) begin
		pixel_item_t nx;
		if (arst_n && (!in_valid || in_ready_seen)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_pixels.size() > 0) begin
				nx = pending_pixels.pop_front();
				in_valid <= 1'b1;
				op <= nx.op;
				red_in <= nx.red;
				green_in <= nx.green;
				blue_in <= nx.blue;
				if (burst_left > 0) burst_left--;
				else begin
					burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(0, 12);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
				end
			end else
				in_valid <= 1'b0;
		end
	end

	// Receiver: picks a new random stall pattern whenever stall_cnt wraps to zero.
	int stall_mode = 0, stall_cnt = 0;
	always @(negedge clk) begin
		if (stall_cnt == 0) stall_mode = $urandom_range(0, 3);
		stall_cnt = (stall_cnt + 1) % 64;
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= $urandom_range(0, 1);
			2: out_ready <= ($urandom_range(0, 3) == 0);
			default: out_ready <= (stall_cnt % 8) < 6;
		endcase
	end

	// Monitor: take accepted items into the predictor, check accepted results.
	always @(posedge clk) begin
		filtered_pixel_t got, want;
		in_ready_seen <= in_valid && in_ready;
		if (arst_n && in_valid && in_ready)
			convolve_item('{op, red_in, green_in, blue_in});
		if (arst_n && out_valid && out_ready) begin
			got = '{red_out, green_out, blue_out, frame_end, clipped};
			if (expected_pixels.size() == 0) begin
				$display("%t: unexpected pixel %h", $realtime, got);
				errors++;
			end else begin
				want = expected_pixels.pop_front();
				if (got !== want) begin
					$display("%t: pixel mismatch expected %h actual %h (r g b last clip)",
						$realtime, want, got);
					errors++;
				end
			end
		end
	end

	task automatic write_reg(input rkc_pkg::cfg_reg_t idx,
			input logic [rkc_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			rkc_pkg::REG_KERNEL_RADIUS: radius_reg = val[1:0];
			rkc_pkg::REG_IMAGE_WIDTH:   width_reg = val[10:0];
			rkc_pkg::REG_IMAGE_HEIGHT:  height_reg = val[10:0];
			default:                    krow[idx - rkc_pkg::REG_KERNEL_ROW_0] = val;
		endcase
	endtask

	// Kernel row flavors: wild random, blur-like, and alternating extremes.
	function automatic logic [rkc_pkg::KROW_W-1:0] make_row(input int flavor);
		logic [rkc_pkg::KROW_W-1:0] r;
		r = rkc_pkg::KROW_W'({$urandom, $urandom});
		if (flavor == 1)
			for (int c = 0; c < 5; c++) r[12 * c +: 12] = 12'($signed($urandom_range(0, 160)) - 64);
		else if (flavor == 2)
			for (int c = 0; c < 5; c++) r[12 * c +: 12] = c[0] ? 12'h7FF : 12'h800;
		return r;
	endfunction

	// Hold until every item is taken and every pixel seen, then let the pipe settle.
	task automatic wait_idle();
		wait (pending_pixels.size() == 0 && !in_valid && expected_pixels.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	// One phase: program all registers, then stream one full frame plus drain.
	task automatic run_frame(input logic [1:0] rad, input logic [10:0] w, input logic [10:0] h,
			input int flavor, inout int counted);
		int ew, eh, er;
		pixel_item_t it;
		wait_idle();
		write_reg(rkc_pkg::REG_KERNEL_RADIUS, rkc_pkg::CFG_DATA_W'(rad));
		write_reg(rkc_pkg::REG_IMAGE_WIDTH, rkc_pkg::CFG_DATA_W'(w));
		write_reg(rkc_pkg::REG_IMAGE_HEIGHT, rkc_pkg::CFG_DATA_W'(h));
		for (int i = 0; i < 5; i++)
			write_reg(rkc_pkg::cfg_reg_t'(rkc_pkg::REG_KERNEL_ROW_0 + i), make_row(flavor));
		ew = clamp_dim(w, 1024);
		eh = clamp_dim(h, 1024);
		er = clamp_dim(rad, 2);
		// Drop a few drains before the frame; they must be ignored.
		it = '{OP_DRAIN, 8'hFF, 8'h00, 8'hA5};
		repeat ($urandom_range(0, 2)) pending_pixels.insert(pending_pixels.size(), it);
		for (int i = 0; i < ew * eh + er * ew + er; i++) begin
			it = '{OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom)};
			if (i == 0) it.op = OP_PIXEL;
			else if (i < ew * eh) it.op = ($urandom_range(0, 19) == 0) ? OP_DRAIN : OP_PIXEL;
			else it.op = ($urandom_range(0, 4) == 0) ? OP_PIXEL : OP_DRAIN;
			pending_pixels.insert(pending_pixels.size(), it);
			counted++;
		end
	endtask

	initial begin
		int counted;
		counted = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// Directed: degenerate geometry, out-of-range registers, extreme kernels.
		run_frame(2'd0, 11'd0, 11'd0, 2, counted);
		run_frame(2'd3, 11'd3, 11'd2, 2, counted);
		run_frame(2'd1, 11'd1, 11'd5, 1, counted);
		run_frame(2'd2, 11'd4, 11'd1, 0, counted);
		run_frame(2'd2, 11'd3, 11'd3, 2, counted);
		// Saturating height.
		run_frame(2'd1, 11'd1, 11'h7FF, 1, counted);
		while (counted < RANDOM_ITEMS)
			run_frame(2'($urandom_range(0, 3)), 11'($urandom_range(1, 12)),
				11'($urandom_range(1, 8)), $urandom_range(0, 2), counted);
		wait_idle();
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire
